// ===== sv/mcbpg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbpg_pkg: shared types and codes of the beep pattern generator
// Command, mode and event codes, and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package mcbpg_pkg;

  // Largest number of channels that the command and result fields can address.
  localparam int MAX_CELLS = 8;

  localparam logic [1:0] OP_SOLID = 2'd0;
  localparam logic [1:0] OP_BEEP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_ON      = 2'd1;
  localparam logic [1:0] MODE_BEEP    = 2'd2;
  localparam logic [1:0] MODE_ONESHOT = 2'd3;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_ON   = 3'd1;
  localparam logic [2:0] EV_OFF  = 3'd2;
  localparam logic [2:0] EV_BEEP = 3'd3;
  localparam logic [2:0] EV_DONE = 3'd4;

  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_POLARITY_MASK = 1'b1;

  // One command plus the result fields that fill in as it passes the cells.
  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  ch;
    logic        turn_on;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [7:0]  pulse_count;
    logic [31:0] t;
    logic        reg_ok;
    logic        acc;
    logic [2:0]  ev;
    logic [2:0]  ev_ch;
    logic [7:0]  done;
    logic [1:0]  mode;
    logic [7:0]  pins;
  } tok_t;

endpackage

// ===== sv/mcbpg_if.sv =====
// ----------------------------------------------------------------------------
// mcbpg_if: command and result channels of the beep pattern generator
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface mcbpg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  channel;
  logic        turn_on;
  logic [15:0] on_time;
  logic [15:0] off_time;
  logic [7:0]  pulse_count;

  modport source (output valid, op, channel, turn_on, on_time, off_time, pulse_count,
                  input ready);
  modport sink (input valid, op, channel, turn_on, on_time, off_time, pulse_count,
                output ready);
endinterface

interface mcbpg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pin_levels;
  logic [2:0]  event_kind;
  logic [2:0]  event_channel;
  logic [7:0]  done_mask;
  logic [1:0]  channel_mode;
  logic [31:0] timestamp;
  logic        accepted;

  modport source (output valid, pin_levels, event_kind, event_channel, done_mask,
                  channel_mode, timestamp, accepted, input ready);
  modport sink (input valid, pin_levels, event_kind, event_channel, done_mask,
                channel_mode, timestamp, accepted, output ready);
endinterface

// ===== sv/multi_channel_beep_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// multi_channel_beep_pattern_generator: buzzer beep pattern generator
// Row of channel cells swept by each command, with a time counter and a
// registered result stage.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_ch (set solid, set beep, tick, query) and each
// one gives exactly one result on out_ch carrying the pin levels after the
// polarity mask, the event, the done mask of a tick, the addressed channel's
// mode, the time counter and the accepted flag.
// A command enters the first cell and moves one cell per cycle, unless the row
// is stalled, down a row of min(CHANNELS, 8) cells, each of which holds one
// channel and applies the command to it. A new command is taken only once the
// previous one has left the last cell, so the row holds one command at most.
// The result register lets the next command enter while a result waits; if
// the receiver stalls, the command at the end of the row holds there until
// the result register frees up. Reset (synchronous, active low) turns all
// channels off, clears the time counter, sets channel_count to 0 and
// polarity_mask to all ones. Configuration is written through cfg_we /
// cfg_index / cfg_wdata; the user must do so only while idle, as the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module multi_channel_beep_pattern_generator #(
  parameter int CHANNELS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  mcbpg_in_if.sink      in_ch,
  mcbpg_out_if.source   out_ch,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_wdata
);
  import mcbpg_pkg::*;

  localparam int NCELL = (CHANNELS > MAX_CELLS) ? MAX_CELLS : CHANNELS;

  logic [3:0]  chan_count_r;
  logic [7:0]  pol_r;
  logic [31:0] time_r, time_nxt;
  logic [3:0]  n_active;

  tok_t           tok_c [NCELL+1];
  logic [NCELL:0] vld_c;
  tok_t           entry;
  logic           in_fire;
  logic           adv;
  logic           entry_reg;

  tok_t out_tok_r;
  logic out_valid_r;

  assign n_active = (chan_count_r > 4'(NCELL)) ? 4'(NCELL) : chan_count_r;
  assign in_fire  = in_ch.valid && in_ch.ready;
  // The row moves unless a finished command sits at its end and the result
  // register is still full.
  assign adv         = !(vld_c[NCELL] && out_valid_r && !out_ch.ready);
  assign in_ch.ready = ~|vld_c[NCELL:1];
  assign time_nxt    = (in_ch.op == OP_TICK) ? time_r + 32'd1 : time_r;
  assign entry_reg   = {1'b0, in_ch.channel} < n_active;

  always_comb begin
    entry              = '0;
    entry.op           = in_ch.op;
    entry.ch           = in_ch.channel;
    entry.turn_on      = in_ch.turn_on;
    entry.on_time      = in_ch.on_time;
    entry.off_time     = in_ch.off_time;
    entry.pulse_count  = in_ch.pulse_count;
    entry.t            = time_nxt;
    entry.reg_ok       = entry_reg;
    entry.acc          = entry_reg;
    entry.ev           = EV_NONE;
    entry.ev_ch        = in_ch.channel;
    unique case (in_ch.op)
      OP_SOLID: begin
        if (entry_reg) begin
          entry.ev = in_ch.turn_on ? EV_ON : EV_OFF;
        end
      end
      OP_BEEP: begin
        if (entry_reg) begin
          entry.ev = EV_BEEP;
        end
      end
      OP_TICK: begin
        entry.acc   = 1'b1;
        entry.ev_ch = 3'd0;
      end
      default: begin
      end
    endcase
  end

  assign tok_c[0] = entry;
  assign vld_c[0] = in_fire;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    mcbpg_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .vld_in   (vld_c[i]),
      .tok_in   (tok_c[i]),
      .n_active (n_active),
      .pol_bit  (pol_r[i]),
      .vld_out  (vld_c[i+1]),
      .tok_out  (tok_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= 4'd0;
      pol_r        <= 8'hFF;
      time_r       <= 32'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CHANNEL_COUNT: chan_count_r <= cfg_wdata[3:0];
          CFG_POLARITY_MASK: pol_r        <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        time_r <= time_nxt;
      end
      if (adv && vld_c[NCELL]) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_c[NCELL]) begin
      out_tok_r <= tok_c[NCELL];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pin_levels    = out_tok_r.pins;
  assign out_ch.event_kind    = out_tok_r.ev;
  assign out_ch.event_channel = out_tok_r.ev_ch;
  assign out_ch.done_mask     = out_tok_r.done;
  assign out_ch.channel_mode  = out_tok_r.mode;
  assign out_ch.timestamp     = out_tok_r.t;
  assign out_ch.accepted      = out_tok_r.acc;

  // Only one command is ever in the cell row.
  a_one_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld_c[NCELL:1]))
    else $error("more than one command in the cell row");

  // An accepted command always lands in the first cell.
  a_enter_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> vld_c[1])
    else $error("accepted command did not enter the cell row");

  // A tick advances the time counter by exactly one.
  a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.op == OP_TICK) |=> (time_r == $past(time_r) + 32'd1))
    else $error("tick did not advance the time counter");

  // A command leaving the last cell shows up as a valid result.
  a_row_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_c[NCELL]) |=> out_valid_r)
    else $error("finished command lost between cell row and result register");

endmodule

// ===== sv/mcbpg_cell.sv =====
// ----------------------------------------------------------------------------
// mcbpg_cell: one buzzer channel
// Holds the channel's mode and phase timing, applies the passing command to
// it and adds its own contribution to the token handed to the next cell.
// ----------------------------------------------------------------------------
module mcbpg_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             vld_in,
  input  mcbpg_pkg::tok_t  tok_in,
  input  logic [3:0]       n_active,
  input  logic             pol_bit,
  output logic             vld_out,
  output mcbpg_pkg::tok_t  tok_out
);
  import mcbpg_pkg::*;

  localparam logic [2:0] ME = 3'(IDX);

  logic [1:0]  mode_r, mode_nxt;
  logic        drive_r, drive_nxt;
  logic        ph_on_r, ph_on_nxt;
  logic [15:0] on_len_r, on_len_nxt;
  logic [15:0] off_len_r, off_len_nxt;
  logic [7:0]  reps_r, reps_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic        vld_r;
  tok_t        tok_r, tok_nxt;

  logic swept;
  logic hit;

  always_comb begin
    mode_nxt    = mode_r;
    drive_nxt   = drive_r;
    ph_on_nxt   = ph_on_r;
    on_len_nxt  = on_len_r;
    off_len_nxt = off_len_r;
    reps_nxt    = reps_r;
    pend_nxt    = pend_r;
    tok_nxt     = tok_in;
    swept       = 4'(IDX) < n_active;
    hit         = tok_in.reg_ok && (tok_in.ch == ME);

    unique case (tok_in.op)
      OP_SOLID: begin
        if (hit) begin
          mode_nxt  = tok_in.turn_on ? MODE_ON : MODE_OFF;
          drive_nxt = tok_in.turn_on;
        end
      end
      OP_BEEP: begin
        if (hit) begin
          mode_nxt    = (tok_in.pulse_count == 8'd0) ? MODE_BEEP : MODE_ONESHOT;
          on_len_nxt  = tok_in.on_time;
          off_len_nxt = tok_in.off_time;
          reps_nxt    = tok_in.pulse_count;
          ph_on_nxt   = 1'b1;
          pend_nxt    = tok_in.t + {16'd0, tok_in.on_time};
          drive_nxt   = 1'b1;
        end
      end
      OP_TICK: begin
        if (swept && (mode_r == MODE_BEEP || mode_r == MODE_ONESHOT) &&
            !(tok_in.t < pend_r)) begin
          ph_on_nxt = ~ph_on_r;
          drive_nxt = ~ph_on_r;
          pend_nxt  = tok_in.t + {16'd0, (ph_on_r ? off_len_r : on_len_r)};
          // Leaving an on-phase of a one-shot uses up one repeat.
          if (ph_on_r && mode_r == MODE_ONESHOT) begin
            if (reps_r != 8'd0) begin
              reps_nxt = reps_r - 8'd1;
            end
            if (reps_r <= 8'd1) begin
              mode_nxt     = MODE_OFF;
              drive_nxt    = 1'b0;
              tok_nxt.done[IDX] = 1'b1;
              if (tok_in.done == 8'd0) begin
                tok_nxt.ev    = EV_DONE;
                tok_nxt.ev_ch = ME;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (hit) begin
      tok_nxt.mode = mode_nxt;
    end
    tok_nxt.pins[IDX] = ~(drive_nxt ^ pol_bit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFF;
      drive_r <= 1'b0;
      vld_r   <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
      if (vld_in) begin
        mode_r  <= mode_nxt;
        drive_r <= drive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
      if (vld_in) begin
        ph_on_r   <= ph_on_nxt;
        on_len_r  <= on_len_nxt;
        off_len_r <= off_len_nxt;
        reps_r    <= reps_nxt;
        pend_r    <= pend_nxt;
      end
    end
  end

  assign vld_out = vld_r;
  assign tok_out = tok_r;

endmodule
